FILE: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms used by the RTL modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is held.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

FILE: sv/bres_pkg.sv
// ----------------------------------------------------------------------------
// Bresenham line walker package
// Widths, command codes and payload types shared by the walker files.
// ----------------------------------------------------------------------------
package bres_pkg;

    // Coordinate width of both axes.
    localparam int COORD_BITS = 11;
    // Stored error term: holds values up to twice the major span, signed.
    localparam int ERR_BITS   = COORD_BITS + 2;
    // Working width for the error update before it settles back in range.
    localparam int ERR_WIDE   = COORD_BITS + 3;
    // Remaining pixel count: up to the major span plus one.
    localparam int LEFT_BITS  = COORD_BITS + 1;

    typedef logic [COORD_BITS-1:0] t_coord;
    typedef logic [LEFT_BITS-1:0]  t_left;

    typedef enum logic {
        CMD_LOAD    = 1'b0,
        CMD_ADVANCE = 1'b1
    } t_cmd;

endpackage

FILE: sv/bres_if.sv
// ----------------------------------------------------------------------------
// Bresenham line walker channels
// Valid/ready interfaces for the command words and the pixel words.
// ----------------------------------------------------------------------------
interface bres_cmd_if;
    import bres_pkg::*;

    logic   valid;
    logic   ready;
    t_cmd   cmd;
    t_coord first_x;
    t_coord first_y;
    t_coord second_x;
    t_coord second_y;

    modport source (output valid, cmd, first_x, first_y, second_x, second_y,
                    input ready);
    modport sink   (input valid, cmd, first_x, first_y, second_x, second_y,
                    output ready);
endinterface

interface bres_pix_if;
    import bres_pkg::*;

    logic   valid;
    logic   ready;
    t_coord pixel_x;
    t_coord pixel_y;
    logic   last_pixel;

    modport source (output valid, pixel_x, pixel_y, last_pixel, input ready);
    modport sink   (input valid, pixel_x, pixel_y, last_pixel, output ready);
endinterface

FILE: sv/bresenham_line_walker_top.sv
// ----------------------------------------------------------------------------
// Bresenham line walker: one pixel word per advance word on an active line.
// A pixel word is registered; it shows the cycle after its advance is taken.
// Throughput: one command word per cycle, limited only by the output register.
// Reset (synchronous, active low) clears the walk and the output valid flag.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bresenham_line_walker_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    bres_cmd_if.sink    i_cmd_if,
    bres_pix_if.source  o_pix_if
);
    import bres_pkg::*;

    // ------------------------------------------------------------------------
    // Walk state. These registers hold the position of the next pixel and the
    // Bresenham decision variables. A load word rewrites all of them; an
    // advance word moves them one step along the line.
    // ------------------------------------------------------------------------
    logic                       r_walking,     n_walking;
    t_coord                     r_cur_x,       n_cur_x;
    t_coord                     r_cur_y,       n_cur_y;
    logic signed [ERR_BITS-1:0] r_error,       n_error;
    t_left                      r_pixels_left, n_pixels_left;
    logic                       r_x_is_major,  n_x_is_major;
    logic                       r_y_goes_down, n_y_goes_down;
    t_coord                     r_major_span,  n_major_span;
    t_coord                     r_minor_span,  n_minor_span;

    // Output register. It decouples the pixel consumer from the command side:
    // a new word is taken whenever the register is empty or is being drained
    // in the same cycle, so a stalled pixel only blocks once it actually waits.
    logic   r_out_valid, n_out_valid;
    t_coord r_pix_x,     n_pix_x;
    t_coord r_pix_y,     n_pix_y;
    logic   r_pix_last,  n_pix_last;

    logic w_accept;
    logic w_emit;

    assign i_cmd_if.ready = !r_out_valid || o_pix_if.ready;
    assign w_accept       = i_cmd_if.valid && i_cmd_if.ready;
    // An advance only produces a pixel while a line is active.
    assign w_emit         = w_accept && (i_cmd_if.cmd == CMD_ADVANCE) && r_walking;

    assign o_pix_if.valid      = r_out_valid;
    assign o_pix_if.pixel_x    = r_pix_x;
    assign o_pix_if.pixel_y    = r_pix_y;
    assign o_pix_if.last_pixel = r_pix_last;

    // ------------------------------------------------------------------------
    // Load decode. The walk always runs toward larger x, so the endpoint with
    // the smaller x becomes the start; on a tie the first endpoint starts.
    // ------------------------------------------------------------------------
    logic   w_swap;
    t_coord w_sx, w_sy, w_ex, w_ey;
    t_coord w_adx, w_ady;
    logic   w_down;
    logic   w_xmaj;

    assign w_swap = i_cmd_if.second_x < i_cmd_if.first_x;
    assign w_sx   = w_swap ? i_cmd_if.second_x : i_cmd_if.first_x;
    assign w_sy   = w_swap ? i_cmd_if.second_y : i_cmd_if.first_y;
    assign w_ex   = w_swap ? i_cmd_if.first_x  : i_cmd_if.second_x;
    assign w_ey   = w_swap ? i_cmd_if.first_y  : i_cmd_if.second_y;
    assign w_adx  = w_ex - w_sx;
    assign w_down = w_ey < w_sy;
    assign w_ady  = w_down ? (w_sy - w_ey) : (w_ey - w_sy);
    // Ties between the spans go to y as the major axis.
    assign w_xmaj = w_adx > w_ady;

    // ------------------------------------------------------------------------
    // Step logic. The major coordinate always moves by one. The error drops by
    // twice the minor span; when it reaches zero or below, the minor
    // coordinate moves too and the error recovers by twice the major span.
    // The wide working value then always lands back in a positive range.
    // ------------------------------------------------------------------------
    logic signed [ERR_WIDE-1:0] w_err_sub;
    logic signed [ERR_WIDE-1:0] w_err_fix;
    logic                       w_minor_step;
    t_coord                     w_y_step;
    t_coord                     w_x_step;

    assign w_err_sub    = ERR_WIDE'(r_error)
                        - signed'(ERR_WIDE'({r_minor_span, 1'b0}));
    assign w_err_fix    = w_err_sub + signed'(ERR_WIDE'({r_major_span, 1'b0}));
    assign w_minor_step = w_err_sub <= 0;
    assign w_x_step     = r_cur_x + 1'b1;
    assign w_y_step     = r_y_goes_down ? (r_cur_y - 1'b1) : (r_cur_y + 1'b1);

    always_comb begin
        n_walking     = r_walking;
        n_cur_x       = r_cur_x;
        n_cur_y       = r_cur_y;
        n_error       = r_error;
        n_pixels_left = r_pixels_left;
        n_x_is_major  = r_x_is_major;
        n_y_goes_down = r_y_goes_down;
        n_major_span  = r_major_span;
        n_minor_span  = r_minor_span;

        n_out_valid   = r_out_valid && !o_pix_if.ready;
        n_pix_x       = r_pix_x;
        n_pix_y       = r_pix_y;
        n_pix_last    = r_pix_last;

        if (w_accept) begin
            case (i_cmd_if.cmd)
                CMD_LOAD: begin
                    // A load drops any active line and starts the new one.
                    n_walking     = 1'b1;
                    n_cur_x       = w_sx;
                    n_cur_y       = w_sy;
                    n_x_is_major  = w_xmaj;
                    n_y_goes_down = w_down;
                    n_major_span  = w_xmaj ? w_adx : w_ady;
                    n_minor_span  = w_xmaj ? w_ady : w_adx;
                    n_error       = signed'(ERR_BITS'(n_major_span));
                    n_pixels_left = LEFT_BITS'(n_major_span) + 1'b1;
                end
                CMD_ADVANCE: begin
                    if (r_walking) begin
                        n_out_valid   = 1'b1;
                        n_pix_x       = r_cur_x;
                        n_pix_y       = r_cur_y;
                        n_pix_last    = r_pixels_left == LEFT_BITS'(1);
                        n_pixels_left = r_pixels_left - 1'b1;
                        if (r_pixels_left == LEFT_BITS'(1)) begin
                            // The end point was just emitted; the walk stops
                            // and the position stays where it is.
                            n_walking = 1'b0;
                        end else begin
                            if (r_x_is_major) begin
                                n_cur_x = w_x_step;
                                if (w_minor_step) begin
                                    n_cur_y = w_y_step;
                                end
                            end else begin
                                n_cur_y = w_y_step;
                                if (w_minor_step) begin
                                    n_cur_x = w_x_step;
                                end
                            end
                            n_error = w_minor_step ? ERR_BITS'(w_err_fix)
                                                   : ERR_BITS'(w_err_sub);
                        end
                    end
                end
                default: begin
                    n_walking = r_walking;
                end
            endcase
        end
    end

    // Control state is cleared by reset; the pixel payload needs no reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_walking     <= 1'b0;
            r_cur_x       <= '0;
            r_cur_y       <= '0;
            r_error       <= '0;
            r_pixels_left <= '0;
            r_x_is_major  <= 1'b0;
            r_y_goes_down <= 1'b0;
            r_major_span  <= '0;
            r_minor_span  <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_walking     <= n_walking;
            r_cur_x       <= n_cur_x;
            r_cur_y       <= n_cur_y;
            r_error       <= n_error;
            r_pixels_left <= n_pixels_left;
            r_x_is_major  <= n_x_is_major;
            r_y_goes_down <= n_y_goes_down;
            r_major_span  <= n_major_span;
            r_minor_span  <= n_minor_span;
            r_out_valid   <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pix_x    <= n_pix_x;
        r_pix_y    <= n_pix_y;
        r_pix_last <= n_pix_last;
    end

    // ------------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------------
    // An active walk always has at least one pixel left to emit.
    `ASSERT_IMPLIES(a_walk_has_pixels, i_clk, i_rst_n, r_walking, r_pixels_left != '0)
    // On any line longer than one pixel the error term stays strictly positive.
    `ASSERT_IMPLIES(a_error_positive, i_clk, i_rst_n, r_walking && (r_major_span != '0), r_error > 0)
    // Emitting the end point ends the walk at the next edge.
    `ASSERT_NEXT(a_last_stops_walk, i_clk, i_rst_n, w_emit && (r_pixels_left == LEFT_BITS'(1)), !r_walking && r_out_valid && r_pix_last)
    // A pixel word that is not the end point keeps the walk going.
    `ASSERT_NEXT(a_mid_keeps_walk, i_clk, i_rst_n, w_emit && (r_pixels_left != LEFT_BITS'(1)), r_walking && r_out_valid && !r_pix_last)

endmodule

FILE: verif/tb.sv
// ----------------------------------------------------------------------------
// Bresenham line walker testbench
// Drives load and advance command words into the walker, predicts every pixel
// word from an independent model of the walk, and checks the pixel stream
// field by field. A short directed table comes first, then random lines of
// mixed shape and length under several source-idle and sink-stall phases.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bres_pkg::*;

    // Random words to send after the directed table; ignored words do not count.
    localparam int RAND_WORDS = 500;
    // Generous cycle budget; a correct run needs a small fraction of it.
    localparam int CYCLE_LIMIT = 200000;
    // Cycles to keep watching the pixel channel after the last expected word.
    localparam int DRAIN_CYCLES = 8;
    localparam int COORD_MAX = (1 << COORD_BITS) - 1;

    // One command word as the source drives it.
    typedef struct {
        t_cmd   cmd;
        t_coord ax;
        t_coord ay;
        t_coord bx;
        t_coord by;
    } t_cmd_word;

    // One pixel word as the walker emits it.
    typedef struct {
        t_coord x;
        t_coord y;
        logic   last;
    } t_pixel;

    // A directed row. When hand_set is high the pixel columns hold the answer
    // worked out by hand, and has_px says whether a pixel word is due at all.
    // Other rows take their expectation from the line predictor.
    typedef struct {
        bit   hand_set;
        t_cmd cmd;
        int   ax;
        int   ay;
        int   bx;
        int   by;
        bit   has_px;
        int   ex;
        int   ey;
        bit   elast;
    } t_dir_row;

    localparam int N_DIR = 24;

    // The directed table walks through the corner cases of the walker:
    // an advance straight after reset, one-pixel lines at both corners of the
    // coordinate range, a full-diagonal right-to-left line, a long shallow
    // line that is cut short by a new load, a vertical line walked downward
    // (equal x values, so the first endpoint is the start), an advance after
    // the line has ended, and a shallow right-to-left line going down.
    // Advance words carry all-ones or all-zeros fields that must be ignored.
    t_dir_row dir_rows [N_DIR] = '{
        '{1'b1, CMD_ADVANCE,    0,    0,    0,    0, 1'b0,    0,    0, 1'b0},
        '{1'b1, CMD_LOAD,       0,    0,    0,    0, 1'b0,    0,    0, 1'b0},
        '{1'b1, CMD_ADVANCE, 2047, 2047, 2047, 2047, 1'b1,    0,    0, 1'b1},
        '{1'b1, CMD_ADVANCE,    0,    0,    0,    0, 1'b0,    0,    0, 1'b0},
        '{1'b1, CMD_LOAD,    2047, 2047, 2047, 2047, 1'b0,    0,    0, 1'b0},
        '{1'b1, CMD_ADVANCE,    0,    0,    0,    0, 1'b1, 2047, 2047, 1'b1},
        '{1'b1, CMD_LOAD,    2047,    0,    0, 2047, 1'b0,    0,    0, 1'b0},
        '{1'b1, CMD_ADVANCE,    0,    0,    0,    0, 1'b1,    0, 2047, 1'b0},
        '{1'b0, CMD_ADVANCE, 2047, 2047, 2047, 2047, 1'b0,    0,    0, 1'b0},
        '{1'b0, CMD_ADVANCE,    0,    0,    0,    0, 1'b0,    0,    0, 1'b0},
        '{1'b1, CMD_LOAD,       0,    0, 2047,    3, 1'b0,    0,    0, 1'b0},
        '{1'b1, CMD_ADVANCE,    0,    0,    0,    0, 1'b1,    0,    0, 1'b0},
        '{1'b0, CMD_ADVANCE,    0,    0,    0,    0, 1'b0,    0,    0, 1'b0},
        '{1'b0, CMD_ADVANCE,    0,    0,    0,    0, 1'b0,    0,    0, 1'b0},
        '{1'b1, CMD_LOAD,       5,    4,    5,    2, 1'b0,    0,    0, 1'b0},
        '{1'b1, CMD_ADVANCE,    0,    0,    0,    0, 1'b1,    5,    4, 1'b0},
        '{1'b0, CMD_ADVANCE,    0,    0,    0,    0, 1'b0,    0,    0, 1'b0},
        '{1'b0, CMD_ADVANCE,    0,    0,    0,    0, 1'b0,    0,    0, 1'b0},
        '{1'b1, CMD_ADVANCE,    0,    0,    0,    0, 1'b0,    0,    0, 1'b0},
        '{1'b1, CMD_LOAD,       9,    1,    3,    3, 1'b0,    0,    0, 1'b0},
        '{1'b1, CMD_ADVANCE,    0,    0,    0,    0, 1'b1,    3,    3, 1'b0},
        '{1'b0, CMD_ADVANCE,    0,    0,    0,    0, 1'b0,    0,    0, 1'b0},
        '{1'b0, CMD_ADVANCE,    0,    0,    0,    0, 1'b0,    0,    0, 1'b0},
        '{1'b0, CMD_ADVANCE,    0,    0,    0,    0, 1'b0,    0,    0, 1'b0}
    };

    logic i_clk = 1'b0;
    logic i_rst_n;

    bres_cmd_if cmd_ch ();
    bres_pix_if pix_ch ();

    bresenham_line_walker_top u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd_if (cmd_ch.sink),
        .o_pix_if (pix_ch.source)
    );

    always #1ns i_clk = ~i_clk;

    // Pixel words still owed by the walker, oldest first.
    t_pixel pending_pixels [$];

    int cycle_cnt = 0;
    int n_fail = 0;
    int n_rand_words = 0;
    // Percent chance per cycle that the source holds back or the sink stalls.
    int src_idle_pct = 0;
    int snk_stall_pct = 0;

    // Walk state of the line predictor, at its reset values.
    bit     line_active = 1'b0;
    t_coord pos_x = '0;
    t_coord pos_y = '0;
    int     err_acc = 0;
    int     pixels_to_go = 0;
    bit     along_x = 1'b0;
    bit     y_down = 1'b0;
    int     span_major = 0;
    int     span_minor = 0;

    always @(posedge i_clk) cycle_cnt <= cycle_cnt + 1;

    // Step the minor or major y coordinate in the direction of the line.
    function automatic t_coord y_stepped(input t_coord y);
        return y_down ? t_coord'(y - 1'b1) : t_coord'(y + 1'b1);
    endfunction

    // Advance the line predictor by one command word. Returns 1 and the pixel
    // when the word makes the walker emit one.
    function automatic bit next_line_pixel(input t_cmd_word w, output t_pixel px);
        t_coord sx, sy, ex, ey;
        int     adx, ady;
        px = '{x: '0, y: '0, last: 1'b0};
        if (w.cmd == CMD_LOAD) begin
            // The walk always runs left to right; ties keep the first endpoint.
            if (w.bx < w.ax) begin
                sx = w.bx; sy = w.by; ex = w.ax; ey = w.ay;
            end else begin
                sx = w.ax; sy = w.ay; ex = w.bx; ey = w.by;
            end
            adx = int'(ex) - int'(sx);
            y_down = (ey < sy);
            ady = y_down ? int'(sy) - int'(ey) : int'(ey) - int'(sy);
            along_x = (adx > ady);
            span_major = along_x ? adx : ady;
            span_minor = along_x ? ady : adx;
            pos_x = sx;
            pos_y = sy;
            err_acc = span_major;
            pixels_to_go = span_major + 1;
            line_active = 1'b1;
            return 1'b0;
        end
        if (!line_active) return 1'b0;

        px.x = pos_x;
        px.y = pos_y;
        px.last = (pixels_to_go == 1);
        pixels_to_go--;
        if (pixels_to_go == 0) begin
            line_active = 1'b0;
            return 1'b1;
        end

        if (along_x) pos_x = t_coord'(pos_x + 1'b1);
        else pos_y = y_stepped(pos_y);
        err_acc -= 2 * span_minor;
        if (err_acc <= 0) begin
            if (along_x) pos_y = y_stepped(pos_y);
            else pos_x = t_coord'(pos_x + 1'b1);
            err_acc += 2 * span_major;
        end
        return 1'b1;
    endfunction

    // Offer one command word, wait for it to be taken, then run the predictor.
    // Must be called at a rising edge; returns at the edge that accepted it.
    task automatic send_word(input t_cmd_word w, output bit got_px, output t_pixel px);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            cmd_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        cmd_ch.valid    <= 1'b1;
        cmd_ch.cmd      <= w.cmd;
        cmd_ch.first_x  <= w.ax;
        cmd_ch.first_y  <= w.ay;
        cmd_ch.second_x <= w.bx;
        cmd_ch.second_y <= w.by;
        do @(posedge i_clk); while (!cmd_ch.ready);
        got_px = next_line_pixel(w, px);
    endtask

    // Random-part wrapper: queue the predicted pixel and count the word
    // unless the walker simply ignores it (an advance with no line active).
    task automatic issue_word(input t_cmd_word w);
        bit     got_px;
        t_pixel px;
        send_word(w, got_px, px);
        if (got_px) pending_pixels.push_back(px);
        if (got_px || w.cmd == CMD_LOAD) n_rand_words++;
    endtask

    // A coordinate near base, kept inside the coordinate range.
    function automatic t_coord coord_near(input t_coord base, input int spread);
        int v;
        v = int'(base) + $urandom_range(0, 2 * spread) - spread;
        if (v < 0) v = 0;
        if (v > COORD_MAX) v = COORD_MAX;
        return t_coord'(v);
    endfunction

    function automatic t_cmd_word advance_word();
        t_cmd_word w;
        // Endpoint fields are don't-care on an advance; fill them with noise.
        w = '{cmd: CMD_ADVANCE, ax: t_coord'($urandom), ay: t_coord'($urandom),
              bx: t_coord'($urandom), by: t_coord'($urandom)};
        return w;
    endfunction

    // Pixel sink: checks every accepted pixel word against the oldest
    // expectation and drives ready with the current stall rate.
    initial begin : pixel_sink
        t_pixel want;
        pix_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && pix_ch.valid && pix_ch.ready) begin
                if (pending_pixels.size() == 0) begin
                    n_fail++;
                    if (n_fail <= 10)
                        $display("unexpected pixel word: x=%0d y=%0d last=%0b",
                                 pix_ch.pixel_x, pix_ch.pixel_y, pix_ch.last_pixel);
                end else begin
                    want = pending_pixels.pop_front();
                    if (pix_ch.pixel_x !== want.x || pix_ch.pixel_y !== want.y ||
                        pix_ch.last_pixel !== want.last) begin
                        n_fail++;
                        if (n_fail <= 10)
                            $display({"pixel mismatch: expected x=%0d y=%0d last=%0b, ",
                                      "got x=%0d y=%0d last=%0b"},
                                     want.x, want.y, want.last, pix_ch.pixel_x,
                                     pix_ch.pixel_y, pix_ch.last_pixel);
                    end
                end
            end
            pix_ch.ready <= ($urandom_range(0, 99) >= snk_stall_pct);
        end
    end

    // Watchdog: a run that hangs or loses pixel words ends here.
    initial begin : watchdog
        while (cycle_cnt < CYCLE_LIMIT) @(posedge i_clk);
        $display("TB_ERROR");
        $finish;
    end

    // Idle/stall rates per phase of the random part, as source and sink pairs.
    int phase_src [5] = '{0, 82, 0, 27, 0};
    int phase_snk [5] = '{0, 0, 82, 27, 0};

    initial begin : stimulus
        t_cmd_word w;
        t_pixel    px;
        bit        got_px;
        int        kind, phase, n_adv;
        t_dir_row  r;

        i_rst_n         <= 1'b0;
        cmd_ch.valid    <= 1'b0;
        cmd_ch.cmd      <= CMD_LOAD;
        cmd_ch.first_x  <= '0;
        cmd_ch.first_y  <= '0;
        cmd_ch.second_x <= '0;
        cmd_ch.second_y <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part, no idling. Hand-set rows override the predictor's
        // answer, which still runs so that its walk state stays in step.
        for (int i = 0; i < N_DIR; i++) begin
            r = dir_rows[i];
            w = '{cmd: r.cmd, ax: t_coord'(r.ax), ay: t_coord'(r.ay),
                  bx: t_coord'(r.bx), by: t_coord'(r.by)};
            send_word(w, got_px, px);
            if (r.hand_set) begin
                if (r.has_px)
                    pending_pixels.push_back('{x: t_coord'(r.ex), y: t_coord'(r.ey),
                                               last: r.elast});
            end else if (got_px) begin
                pending_pixels.push_back(px);
            end
        end

        // Random part, one line sequence at a time. Mostly short lines walked
        // to their end, some long lines cut off by the next load, some lines
        // abandoned part way, and a few stray advances.
        while (n_rand_words < RAND_WORDS) begin
            phase = n_rand_words * 5 / RAND_WORDS;
            if (phase > 4) phase = 4;
            src_idle_pct = phase_src[phase];
            snk_stall_pct = phase_snk[phase];

            kind = $urandom_range(0, 99);
            if (kind < 95) begin
                w.cmd = CMD_LOAD;
                w.ax = t_coord'($urandom);
                w.ay = t_coord'($urandom);
                if (kind >= 70 && kind < 85) begin
                    w.bx = t_coord'($urandom);
                    w.by = t_coord'($urandom);
                end else begin
                    w.bx = coord_near(w.ax, 12);
                    w.by = coord_near(w.ay, 12);
                end
                // Vertical lines exercise the tie on the start point.
                if ($urandom_range(0, 99) < 15) w.bx = w.ax;
                issue_word(w);
            end

            if (kind < 70) begin
                // Walk to the end, sometimes one advance past it.
                while (line_active) issue_word(advance_word());
                if ($urandom_range(0, 99) < 30) issue_word(advance_word());
            end else if (kind < 85) begin
                n_adv = $urandom_range(1, 40);
                for (int k = 0; k < n_adv; k++) issue_word(advance_word());
            end else if (kind < 95) begin
                n_adv = $urandom_range(0, span_major);
                for (int k = 0; k < n_adv; k++) issue_word(advance_word());
            end else begin
                n_adv = $urandom_range(1, 3);
                for (int k = 0; k < n_adv; k++) issue_word(advance_word());
            end
        end

        cmd_ch.valid <= 1'b0;
        src_idle_pct = 0;
        snk_stall_pct = 0;

        // Let every owed pixel arrive, then watch a few cycles for strays.
        while (pending_pixels.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (n_fail == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
